// ===== hdl/interval_set_union_insert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion helpers for the interval set union RTL
// ---------------------------------------------------------------------------
`ifndef INTERVAL_SET_UNION_INSERT_MACROS_SVH
`define INTERVAL_SET_UNION_INSERT_MACROS_SVH

// Check that a condition implies another condition in the same cycle
`define ISU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isu check failed");

// Check that a condition implies another condition in the next cycle
`define ISU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isu check failed");

`endif

// ===== hdl/isu_pkg.sv =====
// ---------------------------------------------------------------------------
// isu_pkg
// Types and constants shared by the interval set union modules.
// ---------------------------------------------------------------------------
package isu_pkg;

    // Code point width and saturation value
    localparam int          CP_W      = 21;
    localparam logic [20:0] CP_MAX    = 21'h1FFFFF;
    localparam int          OUT_CNT_W = 5;

    // Input item
    typedef struct packed {
        logic        clear_first;
        logic [20:0] range_start;
        logic [20:0] range_end;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [20:0] character_count;
        logic [4:0]  range_count;
        logic        dropped;
        logic        bad_range;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic tail;
        logic out_busy;
    } t_status;

endpackage

// ===== hdl/isu_ram.sv =====
// ---------------------------------------------------------------------------
// isu_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while read enable is low.
// ---------------------------------------------------------------------------
module isu_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/isu_ctrl.sv =====
// ---------------------------------------------------------------------------
// isu_ctrl
// Sequencer for one insert: load the item, sweep the table, deliver the
// result into the output register.
// ---------------------------------------------------------------------------
module isu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  isu_pkg::t_status i_status,
    output isu_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.tail) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/isu_dpath.sv =====
// ---------------------------------------------------------------------------
// isu_dpath
// Range table in two banks of one RAM. Each insert streams the old bank
// into the other bank, folding overlapping ranges into the new one,
// slotting the new range in order and summing the covered code points.
// ---------------------------------------------------------------------------
`include "interval_set_union_insert_macros.svh"

module isu_dpath #(
    parameter int MAX_RANGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isu_pkg::t_cmd     i_cmd,
    output isu_pkg::t_status  o_status,
    input  isu_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output isu_pkg::t_out_item o_out_item
);

    localparam int IW        = $clog2(MAX_RANGES);
    localparam int CW        = $clog2(MAX_RANGES + 1);
    localparam int AW        = IW + 1;
    localparam int RAM_DEPTH = 2 * (2 ** IW);
    localparam int ENT_W     = 2 * isu_pkg::CP_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

    // Control registers
    logic          r_bank;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_ri;
    logic [CW-1:0] r_wi;
    logic          r_dv;
    logic          r_ins;
    logic          r_mrg;
    logic          r_drop;
    logic          r_bad;
    logic          r_ovalid;

    // Payload registers
    logic [isu_pkg::CP_W-1:0] r_s;
    logic [isu_pkg::CP_W-1:0] r_e;
    logic [isu_pkg::CP_W-1:0] r_ps;
    logic [isu_pkg::CP_W-1:0] r_pe;
    logic [isu_pkg::CP_W-1:0] r_sum;
    isu_pkg::t_out_item       r_oitem;

    // Next values
    logic                     n_ins;
    logic                     n_mrg;
    logic                     n_drop;
    logic [isu_pkg::CP_W-1:0] n_ps;
    logic [isu_pkg::CP_W-1:0] n_pe;
    logic [isu_pkg::CP_W-1:0] n_sum;

    logic [ENT_W-1:0]         w_rdata;
    logic [isu_pkg::CP_W-1:0] w_rd_s;
    logic [isu_pkg::CP_W-1:0] w_rd_e;
    logic [isu_pkg::CP_W-1:0] w_wd_s;
    logic [isu_pkg::CP_W-1:0] w_wd_e;
    logic                     w_we;
    logic                     w_re;
    logic                     w_consume;
    logic                     w_tail;
    logic                     w_full_new;
    logic [isu_pkg::CP_W:0]   w_len;
    logic [isu_pkg::CP_W:0]   w_sum_raw;
    logic [CW+isu_pkg::OUT_CNT_W-1:0] w_cnt_ext;
    logic [AW-1:0]            w_raddr;
    logic [AW-1:0]            w_waddr;

    assign w_rd_s  = w_rdata[ENT_W-1:isu_pkg::CP_W];
    assign w_rd_e  = w_rdata[isu_pkg::CP_W-1:0];
    assign w_raddr = {r_bank, r_ri[IW-1:0]};
    assign w_waddr = {~r_bank, r_wi[IW-1:0]};

    // Table storage: both banks in one RAM
    isu_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({w_wd_s, w_wd_e}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sweep end and table-full test for a range that overlaps nothing
    assign w_tail     = !r_dv && (r_ri >= r_n);
    assign w_full_new = !r_mrg && (r_n == MAX_CNT);

    // Merge decision for the entry in the read register
    always_comb begin
        w_we      = 1'b0;
        w_wd_s    = w_rd_s;
        w_wd_e    = w_rd_e;
        w_consume = 1'b0;
        n_ins     = r_ins;
        n_mrg     = r_mrg;
        n_drop    = r_drop;
        n_ps      = r_ps;
        n_pe      = r_pe;
        if (i_cmd.scan) begin
            if (r_dv) begin
                if (r_ins || (w_rd_e < r_s)) begin
                    // copy entry unchanged
                    w_we      = 1'b1;
                    w_consume = 1'b1;
                end else if (w_rd_s <= r_e) begin
                    // fold overlapping entry into the pending range
                    w_consume = 1'b1;
                    n_mrg     = 1'b1;
                    n_ps      = (w_rd_s < r_ps) ? w_rd_s : r_ps;
                    n_pe      = (w_rd_e > r_pe) ? w_rd_e : r_pe;
                end else if (w_full_new) begin
                    // drop the new range, copy this entry
                    w_we      = 1'b1;
                    w_consume = 1'b1;
                    n_drop    = 1'b1;
                    n_ins     = 1'b1;
                end else begin
                    // write pending range, hold entry for next cycle
                    w_we   = 1'b1;
                    w_wd_s = r_ps;
                    w_wd_e = r_pe;
                    n_ins  = 1'b1;
                end
            end else if (w_tail && !r_ins) begin
                n_ins = 1'b1;
                if (w_full_new) begin
                    n_drop = 1'b1;
                end else begin
                    w_we   = 1'b1;
                    w_wd_s = r_ps;
                    w_wd_e = r_pe;
                end
            end
        end
    end

    assign w_re = i_cmd.scan && (w_consume || !r_dv) && (r_ri < r_n);

    // Accumulate covered code points with saturation
    always_comb begin
        w_len     = {1'b0, w_wd_e} - {1'b0, w_wd_s} + {{isu_pkg::CP_W{1'b0}}, 1'b1};
        w_sum_raw = {1'b0, r_sum} + (w_we ? w_len : '0);
        n_sum     = w_sum_raw[isu_pkg::CP_W] ? isu_pkg::CP_MAX
                                             : w_sum_raw[isu_pkg::CP_W-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank   <= 1'b0;
            r_cnt    <= '0;
            r_n      <= '0;
            r_ri     <= '0;
            r_wi     <= '0;
            r_dv     <= 1'b0;
            r_ins    <= 1'b0;
            r_mrg    <= 1'b0;
            r_drop   <= 1'b0;
            r_bad    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_n    <= i_in_item.clear_first ? '0 : r_cnt;
                r_ri   <= '0;
                r_wi   <= '0;
                r_dv   <= 1'b0;
                r_ins  <= (i_in_item.range_start > i_in_item.range_end);
                r_bad  <= (i_in_item.range_start > i_in_item.range_end);
                r_mrg  <= 1'b0;
                r_drop <= 1'b0;
            end else if (i_cmd.scan) begin
                r_ri   <= r_ri + CW'(w_re);
                r_wi   <= r_wi + CW'(w_we);
                r_ins  <= n_ins;
                r_mrg  <= n_mrg;
                r_drop <= n_drop;
                if (w_re) begin
                    r_dv <= 1'b1;
                end else if (w_consume) begin
                    r_dv <= 1'b0;
                end
            end
            // Swap banks once the new table is complete
            if (i_cmd.finish) begin
                r_bank <= ~r_bank;
                r_cnt  <= r_wi;
            end
            // Output valid: set on finish, drop when taken
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign w_cnt_ext = {{isu_pkg::OUT_CNT_W{1'b0}}, r_wi};

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s   <= i_in_item.range_start;
            r_e   <= i_in_item.range_end;
            r_ps  <= i_in_item.range_start;
            r_pe  <= i_in_item.range_end;
            r_sum <= '0;
        end else if (i_cmd.scan) begin
            r_ps  <= n_ps;
            r_pe  <= n_pe;
            r_sum <= n_sum;
        end
        if (i_cmd.finish) begin
            r_oitem.character_count <= r_sum;
            r_oitem.range_count     <= w_cnt_ext[isu_pkg::OUT_CNT_W-1:0];
            r_oitem.dropped         <= r_drop;
            r_oitem.bad_range       <= r_bad;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_out_item      = r_oitem;
    assign o_status.tail     = i_cmd.scan && w_tail && (r_ins || n_ins);
    assign o_status.out_busy = r_ovalid && i_out_stall;

    // Checks
    `ISU_ASSERT_IMPLIES(a_wi_bound, i_clk, i_rst_n, 1'b1, r_wi <= MAX_CNT)
    `ISU_ASSERT_IMPLIES(a_drop_nomerge, i_clk, i_rst_n, r_drop, !r_mrg && r_n == MAX_CNT)
    `ISU_ASSERT_IMPLIES(a_write_order, i_clk, i_rst_n, w_we, w_wd_s <= w_wd_e)
    `ISU_ASSERT_IMPLIES(a_bad_copies, i_clk, i_rst_n, r_bad, r_ins && !r_drop)
    `ISU_ASSERT_NEXT(a_finish_valid, i_clk, i_rst_n, i_cmd.finish, r_ovalid)

endmodule

// ===== hdl/interval_set_union_insert.sv =====
// ---------------------------------------------------------------------------
// interval_set_union_insert
// Sorted table of disjoint inclusive code-point ranges. Each item may clear
// the table, then adds one range that merges with every range it overlaps.
// One result per item: covered code points, range count and flags.
//
//   channel  | direction | payload      | handshake
//   ---------+-----------+--------------+--------------------------
//   in       | into      | i_in_item    | i_in_valid / o_in_stall
//   out      | out of    | o_out_item   | o_out_valid / i_out_stall
//
// Each item sweeps the n stored ranges (none after a clear) with one table RAM read
// per range, and no new item is taken until that sweep and the finish are done; the
// result turns valid in the same cycle as the next item can be taken.
// Reset clears the range count; table contents need no clearing pass.
// A new item is taken while an earlier result waits in the output register;
// the finish of the next item waits while that result is stalled.
// ---------------------------------------------------------------------------
module interval_set_union_insert #(
    parameter int MAX_RANGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  isu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output isu_pkg::t_out_item o_out_item
);

    isu_pkg::t_cmd    w_cmd;
    isu_pkg::t_status w_status;

    // Sequencer
    isu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Table and merge datapath
    isu_dpath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
